// ===== sv/length_crc32_packet_framer_core_macros.svh =====
// ----------------------------------------------------------------------------
// length_crc32_packet_framer_core_macros
// assertion macros shared by the framer modules
// ----------------------------------------------------------------------------
`ifndef LENGTH_CRC32_PACKET_FRAMER_CORE_MACROS_SVH
`define LENGTH_CRC32_PACKET_FRAMER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked at every clock edge outside reset
`define LCPF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("framer assertion failed");
// implication checked outside reset
`define LCPF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("framer implication failed");
`else
`define LCPF_ASSERT(lbl, clk, rstn, prop)
`define LCPF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/lcpf_pkg.sv =====
// ----------------------------------------------------------------------------
// lcpf_pkg
// shared types, constants and the crc byte update for the packet framer
// ----------------------------------------------------------------------------
`default_nettype none

package lcpf_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam int unsigned IDX_W = 3;  // up to seven bytes per job

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  localparam logic [IDX_W-1:0] HEAD_BYTES = 3'd3;
  localparam logic [IDX_W-1:0] ONE_BYTE   = 3'd1;
  localparam logic [IDX_W-1:0] TAIL_BYTES = 3'd4;

  // register index on the config port
  localparam logic REG_FRAMING_MODE = 1'b0;

  // input action codes
  localparam logic ACT_BEGIN = 1'b0;
  localparam logic ACT_DATA  = 1'b1;

  // one queued job: optional length header, one byte, optional crc tail
  typedef struct packed {
    logic        head;
    logic        tail;
    logic [15:0] len_field;
    logic [7:0]  data;
    logic [31:0] crc;
  } job_t;

  function automatic logic [31:0] crc_add_byte(input logic [31:0] crc,
                                               input logic [7:0]  b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/lcpf_front.sv =====
// ----------------------------------------------------------------------------
// lcpf_front
// accepts items, tracks frame state and crc, and queues at most one job per item
// ----------------------------------------------------------------------------
`default_nettype none
`include "length_crc32_packet_framer_core_macros.svh"

module lcpf_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire                 cfg_mode_i,
  output logic                mode_o,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire                 action_i,
  input  wire  [7:0]          response_code_i,
  input  wire  [15:0]         payload_length_i,
  input  wire  [7:0]          data_byte_i,
  input  wire                 full_i,
  output logic                push_o,
  output lcpf_pkg::job_t      job_o
);

  logic        mode_q, mode_d;
  logic        in_frame_q, in_frame_d;
  logic [15:0] rem_q, rem_d;
  logic [31:0] crc_q, crc_d;

  logic        accept;
  logic [31:0] crc_src;
  logic [7:0]  crc_byte;
  logic [31:0] crc_new;
  logic [15:0] rem_new;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i & ~full_i;
  assign mode_o     = mode_q;

  assign crc_src  = (action_i == lcpf_pkg::ACT_BEGIN) ? lcpf_pkg::CRC_ONES : crc_q;
  assign crc_byte = (action_i == lcpf_pkg::ACT_BEGIN) ? response_code_i : data_byte_i;
  assign crc_new  = lcpf_pkg::crc_add_byte(crc_src, crc_byte);
  assign rem_new  = rem_q - 16'd1;

  always_comb begin
    mode_d          = mode_q;
    in_frame_d      = in_frame_q;
    rem_d           = rem_q;
    crc_d           = crc_q;
    push_o          = 1'b0;
    job_o.head      = 1'b0;
    job_o.tail      = 1'b0;
    job_o.len_field = payload_length_i + 16'd1;
    job_o.data      = crc_byte;
    job_o.crc       = crc_new ^ lcpf_pkg::CRC_ONES;
    if (cfg_we_i) begin
      mode_d     = cfg_mode_i;
      in_frame_d = 1'b0;
      rem_d      = '0;
      crc_d      = lcpf_pkg::CRC_ONES;
    end else if (accept) begin
      if (!mode_q) begin
        // raw: data passes, begin does nothing
        push_o = (action_i == lcpf_pkg::ACT_DATA);
      end else if (action_i == lcpf_pkg::ACT_BEGIN) begin
        push_o     = 1'b1;
        job_o.head = 1'b1;
        job_o.tail = (payload_length_i == 16'd0);
        if (job_o.tail) begin
          in_frame_d = 1'b0;
          rem_d      = '0;
          crc_d      = lcpf_pkg::CRC_ONES;
        end else begin
          in_frame_d = 1'b1;
          rem_d      = payload_length_i;
          crc_d      = crc_new;
        end
      end else if (in_frame_q) begin
        push_o     = 1'b1;
        job_o.tail = (rem_new == 16'd0);
        if (job_o.tail) begin
          in_frame_d = 1'b0;
          rem_d      = '0;
          crc_d      = lcpf_pkg::CRC_ONES;
        end else begin
          rem_d = rem_new;
          crc_d = crc_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b1;
      in_frame_q <= 1'b0;
      rem_q      <= '0;
      crc_q      <= lcpf_pkg::CRC_ONES;
    end else begin
      mode_q     <= mode_d;
      in_frame_q <= in_frame_d;
      rem_q      <= rem_d;
      crc_q      <= crc_d;
    end
  end

  // outside a frame the crc and byte count sit at their idle values
  `LCPF_ASSERT_IMP(a_idle_state_clean, clk_i, rst_ni, !in_frame_q,
                   rem_q == 16'd0 && crc_q == lcpf_pkg::CRC_ONES)

endmodule

`default_nettype wire

// ===== sv/lcpf_queue.sv =====
// ----------------------------------------------------------------------------
// lcpf_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none
`include "length_crc32_packet_framer_core_macros.svh"

module lcpf_queue (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  lcpf_pkg::job_t  push_data_i,
  output logic            full_o,
  input  wire             pop_i,
  output logic            empty_o,
  output lcpf_pkg::job_t  head_o
);

  lcpf_pkg::job_t                slot_q [lcpf_pkg::QDEPTH];
  logic [lcpf_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [lcpf_pkg::QCNT_W-1:0]  cnt_q;

  assign full_o  = (cnt_q == lcpf_pkg::QCNT_W'(lcpf_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `LCPF_ASSERT(a_no_overflow, clk_i, rst_ni, !(push_i && full_o))
  `LCPF_ASSERT(a_no_underflow, clk_i, rst_ni, !(pop_i && empty_o))

endmodule

`default_nettype wire

// ===== sv/lcpf_back.sv =====
// ----------------------------------------------------------------------------
// lcpf_back
// walks the head job byte by byte into the output register
// ----------------------------------------------------------------------------
`default_nettype none
`include "length_crc32_packet_framer_core_macros.svh"

module lcpf_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 empty_i,
  input  lcpf_pkg::job_t      head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                end_of_packet_o,
  output logic                last_of_run_o
);

  logic [lcpf_pkg::IDX_W-1:0] idx_q, idx_d;
  logic                       out_valid_q;
  logic [7:0]                 out_byte_q;
  logic                       eop_q, last_q;

  logic                       out_free;
  logic [lcpf_pkg::IDX_W-1:0] lead;
  logic [lcpf_pkg::IDX_W-1:0] count;
  logic [lcpf_pkg::IDX_W-1:0] tail_pos;
  logic                       is_last;
  logic [7:0]                 sel_byte;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign lead     = head_i.head ? lcpf_pkg::HEAD_BYTES : lcpf_pkg::ONE_BYTE;
  assign count    = lead + (head_i.tail ? lcpf_pkg::TAIL_BYTES : '0);
  assign is_last  = (idx_q == count - 1'b1);
  assign tail_pos = idx_q - lead;
  assign pop_o    = out_free & ~empty_i & is_last;

  always_comb begin
    if (head_i.head && idx_q == '0) begin
      sel_byte = head_i.len_field[15:8];
    end else if (head_i.head && idx_q == 3'd1) begin
      sel_byte = head_i.len_field[7:0];
    end else if (idx_q == lead - 1'b1) begin
      sel_byte = head_i.data;
    end else begin
      // crc tail, most significant byte first
      case (tail_pos[1:0])
        2'd0:    sel_byte = head_i.crc[31:24];
        2'd1:    sel_byte = head_i.crc[23:16];
        2'd2:    sel_byte = head_i.crc[15:8];
        default: sel_byte = head_i.crc[7:0];
      endcase
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (out_free && !empty_i) begin
      idx_d = is_last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (out_free) begin
        out_valid_q <= ~empty_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && !empty_i) begin
      out_byte_q <= sel_byte;
      eop_q      <= head_i.tail & is_last;
      last_q     <= is_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign end_of_packet_o = eop_q;
  assign last_of_run_o   = last_q;

  // a job is only partly sent while it still sits at the queue head
  `LCPF_ASSERT_IMP(a_idx_idle, clk_i, rst_ni, empty_i, idx_q == '0)

endmodule

`default_nettype wire

// ===== sv/length_crc32_packet_framer_core.sv =====
// ----------------------------------------------------------------------------
// length_crc32_packet_framer_core
// length-prefixed packet framer with crc-32 tail, apb mode register
// output: an item's first byte is registered in the job queue, then in the output register
// throughput: one data byte per cycle while out_stall_i is low; a framed begin
//   item sends length and code (and crc with an empty payload), a closing
//   byte adds a 4-byte crc; the two-entry job queue stalls input while they drain
// reset: framed mode, no frame open, crc at all ones, queue empty
// ----------------------------------------------------------------------------
`default_nettype none

module length_crc32_packet_framer_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire         action_i,
  input  wire  [7:0]  response_code_i,
  input  wire  [15:0] payload_length_i,
  input  wire  [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        end_of_packet_o,
  output logic        last_of_run_o
);

  logic           cfg_we;
  logic           mode;
  logic           push, pop, full, empty;
  lcpf_pkg::job_t job, head;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr[2] == lcpf_pkg::REG_FRAMING_MODE);
  assign prdata = (paddr[2] == lcpf_pkg::REG_FRAMING_MODE) ? {31'd0, mode} : 32'd0;

  lcpf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_mode_i       (pwdata[0]),
    .mode_o           (mode),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .response_code_i  (response_code_i),
    .payload_length_i (payload_length_i),
    .data_byte_i      (data_byte_i),
    .full_i           (full),
    .push_o           (push),
    .job_o            (job)
  );

  lcpf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (job),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  lcpf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .end_of_packet_o (end_of_packet_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

`default_nettype wire
